// ----- rtl/chm_pkg.sv -----
package chm_pkg;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_LOOKUP = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_UNUSED = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_POOL_FULL = 2'd2,
        ST_RESERVED  = 2'd3
    } t_status;

    typedef enum logic [4:0] {
        S_INIT,
        S_IDLE,
        S_INS_SLOT,
        S_INS_HEAD,
        S_INS_LINK,
        S_FIND_HEAD,
        S_FIND_LOAD,
        S_WALK,
        S_CMP,
        S_RCHK,
        S_R_CLR,
        S_R_BKT,
        S_R_BKT_WAIT,
        S_R_ENT,
        S_R_ENT_WAIT,
        S_R_LINK,
        S_FINISH
    } t_state;

    // Load factor limits as integer ratios: grow when 4*count > 3*buckets,
    // shrink when 10*count < buckets, rehash target floor(40*count/17).
    localparam int GROW_NUM   = 4;
    localparam int GROW_DEN   = 3;
    localparam int SHRINK_NUM = 10;
    localparam int TGT_NUM    = 40;
    localparam int TGT_DEN    = 17;

    function automatic logic [63:0] chm_mix(input logic [63:0] k);
        return k ^ (k >> 8) ^ (k >> 16) ^ (k >> 24);
    endfunction

endpackage

// ----- rtl/chm_in_if.sv -----
interface chm_in_if;
    import chm_pkg::*;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [63:0] key;
    logic [63:0] value;

    modport source (output valid, output action, output key, output value, input ready);
    modport sink   (input valid, input action, input key, input value, output ready);
endinterface

// ----- rtl/chm_out_if.sv -----
interface chm_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [63:0] result_value;

    modport source (output valid, output status, output result_value, input ready);
    modport sink   (input valid, input status, input result_value, output ready);
endinterface

// ----- rtl/chm_lg_calc.sv -----
// Smallest bucket log whose power of two covers max(MIN, floor(40*count/17)),
// capped at the largest bucket count.
module chm_lg_calc
    import chm_pkg::*;
#(
    parameter int MIN_BUCKETS = 16,
    parameter int BW          = 12,
    parameter int CW          = 11,
    parameter int LGW         = 4
) (
    input  logic [CW-1:0]  i_count,
    output logic [LGW-1:0] o_lg
);
    localparam int TW = CW + BW + 8;

    logic [TW-1:0] lhs;

    assign lhs = TW'(TGT_NUM) * TW'(i_count);

    // floor(40c/17) <= N  <=>  40c < 17*(N+1)
    always_comb begin
        o_lg = LGW'(BW);
        for (int j = BW; j >= 0; j--) begin
            if (((64'd1 << j) >= 64'(MIN_BUCKETS)) &&
                (lhs < TW'(TGT_DEN) * (TW'(1) << j) + TW'(TGT_DEN))) begin
                o_lg = LGW'(j);
            end
        end
    end
endmodule

// ----- rtl/chained_hash_map_engine_unit.sv -----
// Path, accepting edge to o_out.valid: an insert passes the slot, check, head and link states;
// a refused insert or an unused action goes straight to finish; a lookup or a remove reads the
// bucket head and walks the chain; a rehash clears the new heads and relinks each old entry.
// Throughput: one item at a time; ready is high only while the sequencer idles, and a
// result held by a stalled receiver keeps the sequencer waiting in the finish state.
// Reset: synchronous active-low; 2^initial_log bucket heads (16) clear before ready rises.
module chained_hash_map_engine_unit
    import chm_pkg::*;
#(
    parameter int POOL_ENTRIES = 1024,
    parameter int MAX_BUCKETS  = 4096,
    parameter int MIN_BUCKETS  = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    chm_in_if.sink    i_in,
    chm_out_if.source o_out
);
    // Slot index, link (with the empty marker), count, bucket index widths.
    localparam int IW      = $clog2(POOL_ENTRIES);
    localparam int LW      = $clog2(POOL_ENTRIES + 1);
    localparam int CW      = LW;
    localparam int BW      = $clog2(MAX_BUCKETS + 1) - 1;
    localparam int LGW     = $clog2(BW + 1);
    localparam int INIT_LG = ($clog2(MIN_BUCKETS) > BW) ? BW : $clog2(MIN_BUCKETS);
    localparam int MW      = ((CW > BW) ? CW : BW) + 5;
    localparam logic [LW-1:0] NIL = LW'(POOL_ENTRIES);

    // Two banks of bucket heads: one live, the other the rehash target.
    logic [LW-1:0] bh_mem   [2**(BW+1)];
    logic [63:0]   key_mem  [2**IW];
    logic [63:0]   val_mem  [2**IW];
    logic [LW-1:0] link_mem [2**IW];
    logic [IW-1:0] fs_mem   [2**IW];

    t_state r_state, n_state;

    logic [1:0]     r_action;
    logic [63:0]    r_key, r_value;
    logic [1:0]     r_status;
    logic [63:0]    r_result;
    logic [CW-1:0]  r_count, r_hw;
    logic [LGW-1:0] r_lg, r_new_lg;
    logic           r_bank;
    logic [BW-1:0]  r_cnt, r_idx;
    logic [LW-1:0]  r_e, r_prev, r_next;
    logic [IW-1:0]  r_slot;
    logic           r_need, r_after;
    logic           r_out_valid;
    logic [1:0]     r_out_status;
    logic [63:0]    r_out_value;

    logic [LW-1:0]  bh_q, link_q;
    logic [63:0]    key_q, val_q;
    logic [IW-1:0]  fs_q;

    logic [LGW-1:0] tgt_lg;
    logic [63:0]    key_mix, ent_mix;
    logic [BW-1:0]  key_idx, new_idx;
    logic           hit, accept, out_free;

    logic           bh_we, link_we, kv_we, fs_we;
    logic [BW:0]    bh_waddr, bh_raddr;
    logic [LW-1:0]  bh_wdata, link_wdata;
    logic [IW-1:0]  link_waddr, fs_waddr, fs_wdata;

    logic [CW-1:0]  cnt_inc, cnt_dec;
    logic           grow, shrink;

    function automatic logic [BW-1:0] lg_mask(input logic [LGW-1:0] lg);
        return ~({BW{1'b1}} << lg);
    endfunction

    chm_lg_calc #(
        .MIN_BUCKETS (MIN_BUCKETS),
        .BW          (BW),
        .CW          (CW),
        .LGW         (LGW)
    ) u_lg_calc (
        .i_count (r_count),
        .o_lg    (tgt_lg)
    );

    assign key_mix  = chm_mix(r_key);
    assign ent_mix  = chm_mix(key_q);
    assign key_idx  = key_mix[BW-1:0] & lg_mask(r_lg);
    assign new_idx  = ent_mix[BW-1:0] & lg_mask(r_new_lg);
    assign hit      = (key_q == r_key);
    assign accept   = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign cnt_inc  = r_count + CW'(1);
    assign cnt_dec  = r_count - CW'(1);
    assign grow     = (MW'(GROW_NUM) * MW'(cnt_inc)) > (MW'(GROW_DEN) * (MW'(1) << r_lg));
    assign shrink   = (MW'(SHRINK_NUM) * MW'(cnt_dec)) < (MW'(1) << r_lg);

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_out_status;
    assign o_out.result_value = r_out_value;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT:       if (r_cnt == lg_mask(LGW'(INIT_LG))) n_state = S_IDLE;
            S_IDLE: begin
                if (accept) begin
                    case (t_action'(i_in.action))
                        ACT_INSERT: n_state = (r_count == CW'(POOL_ENTRIES)) ? S_FINISH
                                                                             : S_INS_SLOT;
                        ACT_LOOKUP, ACT_REMOVE: n_state = S_FIND_HEAD;
                        default:    n_state = S_FINISH;
                    endcase
                end
            end
            S_INS_SLOT:   n_state = S_RCHK;
            S_INS_HEAD:   n_state = S_INS_LINK;
            S_INS_LINK:   n_state = S_FINISH;
            S_FIND_HEAD:  n_state = S_FIND_LOAD;
            S_FIND_LOAD:  n_state = S_WALK;
            S_WALK:       n_state = (r_e == NIL) ? S_FINISH : S_CMP;
            S_CMP: begin
                if (!hit) n_state = S_WALK;
                else if (r_action == ACT_REMOVE) n_state = S_RCHK;
                else n_state = S_FINISH;
            end
            S_RCHK: begin
                if (r_need && tgt_lg != r_lg) n_state = S_R_CLR;
                else n_state = r_after ? S_INS_HEAD : S_FINISH;
            end
            S_R_CLR:      if (r_cnt == lg_mask(r_new_lg)) n_state = S_R_BKT;
            S_R_BKT:      n_state = S_R_BKT_WAIT;
            S_R_BKT_WAIT: n_state = S_R_ENT;
            S_R_ENT: begin
                if (r_e != NIL) n_state = S_R_ENT_WAIT;
                else if (r_cnt == lg_mask(r_lg)) n_state = r_after ? S_INS_HEAD : S_FINISH;
                else n_state = S_R_BKT;
            end
            S_R_ENT_WAIT: n_state = S_R_LINK;
            S_R_LINK:     n_state = S_R_ENT;
            S_FINISH:     if (out_free) n_state = S_IDLE;
            default:      n_state = S_INIT;
        endcase
    end

    // Memory controls.
    always_comb begin
        bh_we      = 1'b0;
        bh_waddr   = {r_bank, key_idx};
        bh_wdata   = NIL;
        bh_raddr   = {r_bank, key_idx};
        link_we    = 1'b0;
        link_waddr = r_slot;
        link_wdata = bh_q;
        kv_we      = 1'b0;
        fs_we      = 1'b0;
        fs_waddr   = cnt_dec[IW-1:0];
        fs_wdata   = r_e[IW-1:0];
        unique case (r_state)
            S_INIT: begin
                bh_we    = 1'b1;
                bh_waddr = {1'b0, r_cnt};
            end
            S_INS_LINK: begin
                bh_we    = 1'b1;
                bh_wdata = LW'(r_slot);
                link_we  = 1'b1;
                kv_we    = 1'b1;
            end
            S_CMP: begin
                if (hit && r_action == ACT_REMOVE) begin
                    fs_we = 1'b1;
                    if (r_prev == NIL) begin
                        bh_we    = 1'b1;
                        bh_wdata = link_q;
                    end else begin
                        link_we    = 1'b1;
                        link_waddr = r_prev[IW-1:0];
                        link_wdata = link_q;
                    end
                end
            end
            S_R_CLR: begin
                bh_we    = 1'b1;
                bh_waddr = {~r_bank, r_cnt};
            end
            S_R_BKT:      bh_raddr = {r_bank, r_cnt};
            S_R_ENT_WAIT: bh_raddr = {~r_bank, new_idx};
            S_R_LINK: begin
                bh_we      = 1'b1;
                bh_waddr   = {~r_bank, r_idx};
                bh_wdata   = r_e;
                link_we    = 1'b1;
                link_waddr = r_e[IW-1:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (bh_we) bh_mem[bh_waddr] <= bh_wdata;
        bh_q <= bh_mem[bh_raddr];
        if (link_we) link_mem[link_waddr] <= link_wdata;
        if (kv_we) begin
            key_mem[r_slot] <= r_key;
            val_mem[r_slot] <= r_value;
        end
        key_q  <= key_mem[r_e[IW-1:0]];
        val_q  <= val_mem[r_e[IW-1:0]];
        link_q <= link_mem[r_e[IW-1:0]];
        if (fs_we) fs_mem[fs_waddr] <= fs_wdata;
        fs_q <= fs_mem[r_count[IW-1:0]];
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_count     <= '0;
            r_hw        <= '0;
            r_lg        <= LGW'(INIT_LG);
            r_bank      <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // Load a new result when the output register frees up, else drop it once taken.
            if (r_state == S_FINISH && out_free) r_out_valid <= 1'b1;
            else if (o_out.ready) r_out_valid <= 1'b0;
            unique case (r_state)
                S_INIT:     r_cnt <= r_cnt + BW'(1);
                S_INS_SLOT: begin
                    r_count <= cnt_inc;
                    if (cnt_inc > r_hw) r_hw <= cnt_inc;
                end
                S_CMP:      if (hit && r_action == ACT_REMOVE) r_count <= cnt_dec;
                S_RCHK:     r_cnt <= '0;
                S_R_CLR:    r_cnt <= (r_cnt == lg_mask(r_new_lg)) ? '0 : r_cnt + BW'(1);
                S_R_ENT: begin
                    if (r_e == NIL) begin
                        if (r_cnt == lg_mask(r_lg)) begin
                            // Swap in the rebuilt bank.
                            r_bank <= ~r_bank;
                            r_lg   <= r_new_lg;
                        end else begin
                            r_cnt <= r_cnt + BW'(1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_action <= i_in.action;
                    r_key    <= i_in.key;
                    r_value  <= i_in.value;
                    r_result <= '0;
                    r_status <= (t_action'(i_in.action) == ACT_INSERT) ? ST_POOL_FULL
                                                                       : ST_NOT_FOUND;
                end
            end
            S_INS_SLOT: begin
                // Stack positions at or above the high-water mark were never written.
                r_slot  <= (r_count >= r_hw) ? r_count[IW-1:0] : fs_q;
                r_need  <= grow;
                r_after <= 1'b1;
            end
            S_INS_LINK: begin
                r_status <= ST_DONE;
                r_result <= r_value;
            end
            S_FIND_LOAD: begin
                r_e    <= bh_q;
                r_prev <= NIL;
            end
            S_CMP: begin
                if (hit) begin
                    r_status <= ST_DONE;
                    r_result <= val_q;
                    r_need   <= shrink;
                    r_after  <= 1'b0;
                end else begin
                    r_prev <= r_e;
                    r_e    <= link_q;
                end
            end
            S_RCHK:       r_new_lg <= tgt_lg;
            S_R_BKT_WAIT: r_e <= bh_q;
            S_R_ENT_WAIT: begin
                r_next <= link_q;
                r_idx  <= new_idx;
            end
            S_R_LINK:     r_e <= r_next;
            S_FINISH: begin
                if (out_free) begin
                    r_out_status <= r_status;
                    r_out_value  <= r_result;
                end
            end
            default: ;
        endcase
    end
endmodule
